@@ design/lzwe_pkg.sv @@
// Shared types and constants of the LZW byte encoder.
`timescale 1ns / 1ps

package lzwe_pkg;

	localparam int DEF_HASH_SLOTS = 16411;
	localparam int DEF_HASH_SHIFT = 6;
	localparam int MAX_BITS       = 12;

	localparam logic [11:0] CODE_CLEAR = 12'd256;
	localparam logic [11:0] CODE_END   = 12'd257;
	localparam logic [12:0] CODE_FIRST = 13'd258;
	localparam logic [3:0]  WIDTH_MIN  = 4'd9;
	localparam logic [3:0]  WIDTH_MAX  = 4'(MAX_BITS);

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic REG_MAX_CODE_BITS = 1'b0;
	localparam logic REG_GIF_MODE      = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic [11:0] code_value;
		logic [3:0]  code_width;
		logic        last_of_run;
	} code_item_t;

	typedef struct packed {
		logic        used;
		logic        noprefix;
		logic [11:0] prefix;
		logic [11:0] code;
		logic [7:0]  suffix;
	} dict_entry_t;

endpackage

@@ design/lzwe_alu.sv @@
// Shared add/subtract unit used for hash reduction and probe stepping.
`timescale 1ns / 1ps

module lzwe_alu #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] y,
	output logic         borrow
);

	logic [W:0] sum;

	assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign y      = sum[W-1:0];
	// carry out clear on a subtract means a < b
	assign borrow = sub & ~sum[W];

endmodule

@@ design/lzwe_dict.sv @@
// Dictionary slot RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module lzwe_dict
	import lzwe_pkg::*;
#(
	parameter int DEPTH  = DEF_HASH_SLOTS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  dict_entry_t       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output dict_entry_t       rd_data
);

	dict_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/lzw_byte_encoder_core.sv @@
// LZW byte encoder top level: sequencer, code state and output register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  byte     | byte_valid / byte_ready  | byte_item (opcode, data_byte)
//  code     | code_valid / code_ready  | code_item (value, width, last)
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data (always ready)
//
// A data byte is hashed and probed slot by slot; a new string is added on a miss
// and each code is emitted through the output register; all hash and probe
// arithmetic goes through one add/subtract unit.
// A dictionary clear sweeps the slot RAM one slot a cycle, then seeds 256 root
// slots; byte_ready stays low meanwhile.
// After reset the same clear runs before the first byte is taken.
// A stalled code channel holds the sequencer only in its emit states.
`timescale 1ns / 1ps

module lzw_byte_encoder_core
	import lzwe_pkg::*;
#(
	parameter int HASH_SLOTS = DEF_HASH_SLOTS,
	parameter int HASH_SHIFT = DEF_HASH_SHIFT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  byte_item_t byte_item,
	output logic       code_valid,
	input  logic       code_ready,
	output code_item_t code_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);

	localparam int SLOT_W = $clog2(HASH_SLOTS);
	localparam int HX_W   = (8 + HASH_SHIFT > 12) ? 8 + HASH_SHIFT : 12;
	localparam int ALU_W  = ((HX_W > SLOT_W) ? HX_W : SLOT_W) + 1;
	localparam int PC_W   = $clog2(HASH_SLOTS + 1);

	localparam logic [SLOT_W-1:0] SLOTS_S = SLOT_W'(HASH_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_S  = SLOT_W'(HASH_SLOTS - 1);
	localparam logic [ALU_W-1:0]  SLOTS_A = ALU_W'(HASH_SLOTS);
	localparam logic [PC_W-1:0]   SLOTS_C = PC_W'(HASH_SLOTS);

	typedef enum logic [15:0] {
		S_CLEAR     = 16'b0000_0000_0000_0001,
		S_SEED_LD   = 16'b0000_0000_0000_0010,
		S_SEED_MOD  = 16'b0000_0000_0000_0100,
		S_IDLE      = 16'b0000_0000_0000_1000,
		S_EMIT_PEND = 16'b0000_0000_0001_0000,
		S_EMIT_END  = 16'b0000_0000_0010_0000,
		S_EMIT_CLR  = 16'b0000_0000_0100_0000,
		S_HASH_LD   = 16'b0000_0000_1000_0000,
		S_HASH_MOD  = 16'b0000_0001_0000_0000,
		S_OFF       = 16'b0000_0010_0000_0000,
		S_RD        = 16'b0000_0100_0000_0000,
		S_CMP       = 16'b0000_1000_0000_0000,
		S_WRAP      = 16'b0001_0000_0000_0000,
		S_INS       = 16'b0010_0000_0000_0000,
		S_CHK       = 16'b0100_0000_0000_0000,
		S_EMIT_HOLD = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	logic [3:0]        max_bits_q;
	logic              gif_q;
	logic [3:0]        width_q;
	logic [12:0]       next_q;
	logic              pend_valid_q;
	logic              dict_clean_q;
	logic              have_hold_q;
	logic              clr_q;
	logic [SLOT_W-1:0] clr_addr_q;
	logic [7:0]        seed_q;
	logic [PC_W-1:0]   cnt_q;
	logic              code_valid_q;
	code_item_t        code_item_q;

	logic [11:0]       pend_q;
	logic [7:0]        byte_q;
	logic [ALU_W-1:0]  x_q;
	logic [SLOT_W-1:0] h_q;
	logic [SLOT_W-1:0] off_q;
	logic [11:0]       hold_code_q;
	logic [3:0]        hold_width_q;

	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	logic              alu_sub;
	logic [ALU_W-1:0]  alu_y;
	logic              alu_borrow;

	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	dict_entry_t       wr_data;
	logic              rd_en;
	dict_entry_t       rd_data;

	logic [ALU_W-1:0]  hash_x;
	logic [12:0]       next_inc;
	logic [12:0]       grow_lim;
	logic              grow;
	logic [3:0]        eff_bits;
	logic [12:0]       clr_lim;
	logic              need_clr;
	logic              hit;
	logic              push_ok;
	logic              emit;
	code_item_t        emit_item;
	logic              accept;

	lzwe_alu #(
		.W(ALU_W)
	) u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.sub    (alu_sub),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	lzwe_dict #(
		.DEPTH  (HASH_SLOTS),
		.ADDR_W (SLOT_W)
	) u_dict (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (h_q),
		.rd_data (rd_data)
	);

	assign byte_ready = (state_q == S_IDLE);
	assign accept     = byte_valid & byte_ready;
	assign cfg_ready  = 1'b1;
	assign code_valid = code_valid_q;
	assign code_item  = code_item_q;

	assign hash_x   = ALU_W'(pend_q) ^ (ALU_W'(byte_q) << HASH_SHIFT);
	assign next_inc = next_q + 13'd1;
	assign grow_lim = (13'd1 << width_q) + {12'd0, gif_q};
	assign grow     = (next_inc >= grow_lim) && (width_q < WIDTH_MAX);
	assign eff_bits = (max_bits_q < WIDTH_MIN) ? WIDTH_MIN :
		((max_bits_q > WIDTH_MAX) ? WIDTH_MAX : max_bits_q);
	assign clr_lim  = (13'd1 << eff_bits) - 13'd1;
	assign need_clr = (next_q >= clr_lim);
	assign hit      = !rd_data.noprefix && (rd_data.suffix == byte_q) &&
		(rd_data.prefix == pend_q);
	assign push_ok  = !code_valid_q || code_ready;
	assign rd_en    = (state_q == S_RD);

	// operand select for the shared add/subtract unit
	always_comb begin
		alu_a   = x_q;
		alu_b   = SLOTS_A;
		alu_sub = 1'b1;
		case (state_q)
			S_OFF: begin
				alu_a = SLOTS_A;
				alu_b = ALU_W'(h_q);
			end
			S_CMP: begin
				alu_a = ALU_W'(h_q);
				alu_b = ALU_W'(off_q);
			end
			S_WRAP: begin
				alu_a   = ALU_W'(h_q);
				alu_b   = SLOTS_A;
				alu_sub = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = h_q;
		wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
			end
			S_SEED_MOD: begin
				wr_en   = alu_borrow;
				wr_addr = x_q[SLOT_W-1:0];
				wr_data = '{used: 1'b1, noprefix: 1'b1, prefix: 12'd0,
					code: {4'd0, seed_q}, suffix: seed_q};
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_data = '{used: 1'b1, noprefix: 1'b0, prefix: pend_q,
					code: next_q[11:0], suffix: byte_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_item = '{code_value: CODE_END, code_width: width_q, last_of_run: 1'b1};
		case (state_q)
			S_EMIT_PEND: begin
				emit      = 1'b1;
				emit_item = '{code_value: pend_q, code_width: width_q, last_of_run: 1'b0};
			end
			S_EMIT_END: begin
				emit = 1'b1;
			end
			S_EMIT_CLR: begin
				emit      = 1'b1;
				emit_item = '{code_value: CODE_CLEAR, code_width: width_q,
					last_of_run: 1'b1};
			end
			S_EMIT_HOLD: begin
				emit      = 1'b1;
				emit_item = '{code_value: hold_code_q, code_width: hold_width_q,
					last_of_run: !clr_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (emit && push_ok) begin
			code_valid_q <= 1'b1;
		end else if (code_ready) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && push_ok) begin
			code_item_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bits_q <= WIDTH_MAX;
			gif_q      <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_CODE_BITS: max_bits_q <= cfg_data;
				REG_GIF_MODE:      gif_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and code state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			width_q      <= WIDTH_MIN;
			next_q       <= CODE_FIRST;
			pend_valid_q <= 1'b0;
			dict_clean_q <= 1'b0;
			have_hold_q  <= 1'b0;
			clr_q        <= 1'b0;
			clr_addr_q   <= '0;
			seed_q       <= '0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_addr_q == LAST_S) begin
						seed_q  <= '0;
						state_q <= S_SEED_LD;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				S_SEED_LD: state_q <= S_SEED_MOD;
				S_SEED_MOD: begin
					if (alu_borrow) begin
						if (seed_q == 8'hFF) begin
							dict_clean_q <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							seed_q  <= seed_q + 8'd1;
							state_q <= S_SEED_LD;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (byte_item.opcode == OP_FLUSH) begin
							pend_valid_q <= 1'b0;
							state_q      <= pend_valid_q ? S_EMIT_PEND : S_EMIT_END;
						end else if (!pend_valid_q) begin
							pend_valid_q <= 1'b1;
							state_q      <= S_EMIT_CLR;
						end else begin
							state_q <= S_HASH_LD;
						end
					end
				end
				S_EMIT_PEND: begin
					if (push_ok) begin
						state_q <= S_EMIT_END;
					end
				end
				S_EMIT_END: begin
					if (push_ok) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT_CLR: begin
					if (push_ok) begin
						width_q    <= WIDTH_MIN;
						next_q     <= CODE_FIRST;
						clr_addr_q <= '0;
						state_q    <= dict_clean_q ? S_IDLE : S_CLEAR;
					end
				end
				S_HASH_LD: state_q <= S_HASH_MOD;
				S_HASH_MOD: begin
					if (alu_borrow) begin
						cnt_q   <= '0;
						state_q <= S_OFF;
					end
				end
				S_OFF: state_q <= S_RD;
				S_RD:  state_q <= S_CMP;
				S_CMP: begin
					if (!rd_data.used) begin
						state_q <= S_INS;
					end else if (hit) begin
						have_hold_q <= 1'b0;
						state_q     <= S_CHK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (alu_borrow) begin
							state_q <= S_WRAP;
						end else if (cnt_q + 1'b1 == SLOTS_C) begin
							state_q <= S_INS;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_WRAP: state_q <= (cnt_q == SLOTS_C) ? S_INS : S_RD;
				S_INS: begin
					next_q       <= next_inc;
					dict_clean_q <= 1'b0;
					have_hold_q  <= 1'b1;
					if (grow) begin
						width_q <= width_q + 4'd1;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					clr_q <= need_clr;
					if (have_hold_q) begin
						state_q <= S_EMIT_HOLD;
					end else begin
						state_q <= need_clr ? S_EMIT_CLR : S_IDLE;
					end
				end
				S_EMIT_HOLD: begin
					if (push_ok) begin
						state_q <= clr_q ? S_EMIT_CLR : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_SEED_LD: x_q <= ALU_W'(seed_q) << HASH_SHIFT;
			S_SEED_MOD: begin
				if (!alu_borrow) begin
					x_q <= alu_y;
				end
			end
			S_IDLE: begin
				if (accept) begin
					byte_q <= byte_item.data_byte;
					if (byte_item.opcode == OP_ENCODE && !pend_valid_q) begin
						pend_q <= {4'd0, byte_item.data_byte};
					end
				end
			end
			S_HASH_LD: x_q <= hash_x;
			S_HASH_MOD: begin
				if (alu_borrow) begin
					h_q <= x_q[SLOT_W-1:0];
				end else begin
					x_q <= alu_y;
				end
			end
			S_OFF: off_q <= (h_q == '0) ? SLOT_W'(1) : alu_y[SLOT_W-1:0];
			S_CMP: begin
				if (rd_data.used) begin
					if (hit) begin
						pend_q <= rd_data.code;
					end else begin
						h_q <= alu_y[SLOT_W-1:0];
					end
				end
			end
			// step went below zero: add the table size back
			S_WRAP: h_q <= alu_y[SLOT_W-1:0];
			S_INS: begin
				hold_code_q  <= pend_q;
				hold_width_q <= width_q;
				pend_q       <= {4'd0, byte_q};
			end
			default: begin
			end
		endcase
	end

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		(width_q >= WIDTH_MIN) && (width_q <= WIDTH_MAX))
		else $error("code width out of range");

	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q >= CODE_FIRST) && (next_q <= 13'd4095))
		else $error("next code out of range");

	a_probe_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (h_q < SLOTS_S))
		else $error("probe slot beyond table");

	a_probe_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOTS_C)
		else $error("probe count overran table size");

	a_flush_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_item.opcode == OP_FLUSH) |=> !pend_valid_q)
		else $error("pending code kept after flush");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the LZW byte encoder core.
`timescale 1ns / 1ps

module tb
	import lzwe_pkg::*;
();

	localparam int SLOTS          = DEF_HASH_SLOTS;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 200;
	localparam int WATCHDOG_LIMIT = 100000;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	byte_item_t byte_item  = '0;
	logic       code_valid;
	logic       code_ready = 1'b0;
	code_item_t code_item;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic       cfg_index  = REG_MAX_CODE_BITS;
	logic [3:0] cfg_data   = 4'd0;

	// encoder state as the checker sees it
	dict_entry_t dict_tab [SLOTS];
	logic [3:0]  width_cur;
	logic [12:0] next_free;
	logic [11:0] pend_code;
	logic        pend_ok;
	logic [3:0]  cfg_max_bits = 4'd12;
	logic        cfg_gif      = 1'b1;
	code_item_t  codes_due [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;
	int idle_cycles   = 0;
	int errors        = 0;
	int items_sent    = 0;
	int codes_seen    = 0;
	int clears_seen   = 0;
	int widest        = 0;

	lzw_byte_encoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_item  (code_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int slot_of(input logic [11:0] prefix, input logic [7:0] b);
		return (int'(prefix) ^ (int'(b) << DEF_HASH_SHIFT)) % SLOTS;
	endfunction

	function automatic void dict_reset();
		int h;
		foreach (dict_tab[i])
			dict_tab[i] = '0;
		for (int i = 0; i < 256; i++) begin
			h = slot_of(12'd0, 8'(i));
			dict_tab[h].used     = 1'b1;
			dict_tab[h].noprefix = 1'b1;
			dict_tab[h].code     = 12'(i);
			dict_tab[h].suffix   = 8'(i);
		end
		width_cur = WIDTH_MIN;
		next_free = CODE_FIRST;
	endfunction

	// double-hash probe; slot gets the match or the insertion point
	function automatic bit dict_lookup(input logic [11:0] prefix, input logic [7:0] b,
			output int slot);
		int h;
		int stride;
		h = slot_of(prefix, b);
		stride = (h != 0) ? SLOTS - h : 1;
		for (int n = 0; n < SLOTS; n++) begin
			if (!dict_tab[h].used)
				break;
			if (!dict_tab[h].noprefix && dict_tab[h].suffix == b &&
					dict_tab[h].prefix == prefix) begin
				slot = h;
				return 1'b1;
			end
			h = (h >= stride) ? h - stride : h + SLOTS - stride;
		end
		slot = h;
		return 1'b0;
	endfunction

	function automatic void expect_code(input logic [11:0] value, input logic last);
		code_item_t c;
		c.code_value  = value;
		c.code_width  = width_cur;
		c.last_of_run = last;
		codes_due.push_back(c);
	endfunction

	function automatic void lzw_predict(input byte_item_t it);
		int slot;
		int grow_at;
		int top_bits;
		bit emitted;
		code_item_t c;
		emitted = 1'b0;
		if (it.opcode == OP_FLUSH) begin
			if (pend_ok)
				expect_code(pend_code, 1'b0);
			expect_code(CODE_END, 1'b1);
			pend_ok = 1'b0;
			return;
		end
		if (!pend_ok) begin
			expect_code(CODE_CLEAR, 1'b1);
			dict_reset();
			pend_code = {4'b0000, it.data_byte};
			pend_ok   = 1'b1;
			return;
		end
		if (dict_lookup(pend_code, it.data_byte, slot)) begin
			pend_code = dict_tab[slot].code;
		end else begin
			expect_code(pend_code, 1'b1);
			emitted = 1'b1;
			dict_tab[slot].used     = 1'b1;
			dict_tab[slot].noprefix = 1'b0;
			dict_tab[slot].prefix   = pend_code;
			dict_tab[slot].code     = next_free[11:0];
			dict_tab[slot].suffix   = it.data_byte;
			next_free = next_free + 13'd1;
			grow_at = (1 << width_cur) + (cfg_gif ? 1 : 0);
			if (int'(next_free) >= grow_at && width_cur < WIDTH_MAX)
				width_cur = width_cur + 4'd1;
			pend_code = {4'b0000, it.data_byte};
		end
		top_bits = cfg_max_bits;
		if (top_bits < WIDTH_MIN)
			top_bits = WIDTH_MIN;
		if (top_bits > MAX_BITS)
			top_bits = MAX_BITS;
		if (int'(next_free) >= (1 << top_bits) - 1) begin
			// table full: the clear code becomes the last word of this item
			if (emitted) begin
				c = codes_due.pop_back();
				c.last_of_run = 1'b0;
				codes_due.push_back(c);
			end
			expect_code(CODE_CLEAR, 1'b1);
			dict_reset();
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		errors++;
	endtask

	// valid stays up between back-to-back words; gaps lower it
	task automatic send_item(input logic op, input logic [7:0] data);
		byte_item_t it;
		it.opcode    = op;
		it.data_byte = data;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		do @(posedge clk); while (!byte_ready);
		items_sent++;
		lzw_predict(it);
	endtask

	task automatic set_config(input logic [3:0] max_bits, input logic gif);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MAX_CODE_BITS;
		cfg_data  <= max_bits;
		do @(posedge clk); while (!cfg_ready);
		cfg_max_bits = max_bits;
		cfg_index <= REG_GIF_MODE;
		cfg_data  <= {3'b000, gif};
		do @(posedge clk); while (!cfg_ready);
		cfg_gif = gif;
		cfg_valid <= 1'b0;
	endtask

	// a flush leaves the encoder idle once its end code is out
	task automatic finish_phase();
		send_item(OP_FLUSH, 8'($urandom));
		byte_valid <= 1'b0;
		while (codes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// runs of a small alphabet and of short repeated patterns build long matches;
	// noise runs add fresh strings and fill the table
	task automatic random_stream(input int count, input int noise_pct);
		int left;
		int run;
		int kind;
		logic [7:0] base;
		logic [7:0] pat [4];
		left = count;
		while (left > 0) begin
			kind = $urandom_range(99);
			run  = $urandom_range(4, 40);
			base = 8'($urandom);
			for (int k = 0; k < 4; k++)
				pat[k] = 8'($urandom);
			for (int k = 0; k < run && left > 0; k++) begin
				if ($urandom_range(299) == 0)
					send_item(OP_FLUSH, 8'($urandom));
				else if (kind < noise_pct)
					send_item(OP_ENCODE, 8'($urandom));
				else if (kind < noise_pct + (100 - noise_pct) / 2)
					send_item(OP_ENCODE, base ^ 8'($urandom_range(3)));
				else
					send_item(OP_ENCODE, pat[k % 4]);
				left--;
			end
		end
	endtask

	task automatic test_directed();
		send_item(OP_FLUSH, 8'h00);	// nothing pending: end code only
		send_item(OP_FLUSH, 8'hFF);
		send_item(OP_ENCODE, 8'h00);	// first byte: clear code, byte becomes the prefix
		send_item(OP_ENCODE, 8'hFF);
		send_item(OP_ENCODE, 8'hFF);
		send_item(OP_ENCODE, 8'hFF);
		send_item(OP_ENCODE, 8'hFF);
		send_item(OP_ENCODE, 8'hFF);
		send_item(OP_ENCODE, 8'h00);
		send_item(OP_ENCODE, 8'hFF);
		send_item(OP_ENCODE, 8'h00);
		send_item(OP_ENCODE, 8'hFF);
		send_item(OP_ENCODE, 8'h55);
		send_item(OP_ENCODE, 8'hAA);
		send_item(OP_FLUSH, 8'h3C);	// pending code, then end code
		send_item(OP_ENCODE, 8'h80);
		send_item(OP_ENCODE, 8'h7F);
		send_item(OP_ENCODE, 8'h7F);
		finish_phase();
	endtask

	task automatic test_narrow_tables();
		set_config(4'd9, 1'b1);
		random_stream(320, 70);
		finish_phase();
		set_config(4'd0, 1'b0);	// below range: clamps to 9 bits
		random_stream(300, 70);
		finish_phase();
	endtask

	task automatic test_wide_tables();
		set_config(4'd10, 1'b0);
		random_stream(450, 60);
		finish_phase();
	endtask

	task automatic test_backpressure();
		set_config(4'd15, 1'b1);	// above range: clamps to the widest table
		hold_req = 1'b1;
		random_stream(40, 30);
		byte_valid <= 1'b0;
		while (codes_due.size() != 0)
			@(posedge clk);
		random_stream(100, 30);
		finish_phase();
	endtask

	task automatic test_mixed_random();
		set_config(4'd11, 1'b1);
		random_stream(200, 40);
		finish_phase();
		set_config(4'd9, 1'b0);
		random_stream(170, 80);
		finish_phase();
	endtask

	// check each accepted code word, then drive ready for the next cycle
	always @(posedge clk) begin
		code_item_t want;
		if (arst_n && code_valid && code_ready) begin
			codes_seen++;
			if (code_item.code_value == CODE_CLEAR)
				clears_seen++;
			if (int'(code_item.code_width) > widest)
				widest = code_item.code_width;
			if (codes_due.size() == 0) begin
				report_mismatch($sformatf("unexpected code word value=%0d width=%0d",
					code_item.code_value, code_item.code_width));
			end else begin
				want = codes_due.pop_front();
				if (code_item.code_value !== want.code_value)
					report_mismatch($sformatf("code_value %0d, want %0d",
						code_item.code_value, want.code_value));
				if (code_item.code_width !== want.code_width)
					report_mismatch($sformatf("code_width %0d, want %0d (code %0d)",
						code_item.code_width, want.code_width, want.code_value));
				if (code_item.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %0b, want %0b (code %0d)",
						code_item.last_of_run, want.last_of_run, want.code_value));
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			code_ready <= 1'b0;
		end else begin
			code_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (code_valid && code_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		pend_code = 12'd0;
		pend_ok   = 1'b0;
		dict_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 27;
		recv_idle_pct = 46;
		test_directed();
		test_narrow_tables();
		send_idle_pct = 46;
		recv_idle_pct = 27;
		test_wide_tables();
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_mixed_random();
		if (codes_due.size() != 0)
			report_mismatch($sformatf("%0d code words never arrived", codes_due.size()));
		$display("Summary: %0d byte/flush words in, %0d code words checked, %0d clear codes",
			items_sent, codes_seen, clears_seen);
		$display("Summary: table limits 9..12 bits incl. clamped values, %s%0d bits",
			"both width modes, widest code ", widest);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/lzwe_pkg.sv
design/lzwe_alu.sv
design/lzwe_dict.sv
design/lzw_byte_encoder_core.sv
tb/tb.sv
